>>> rtl/arpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpt_pkg
// Shared types, constants and the coefficient table builder for the
// principal-axis point rotation block.
// ----------------------------------------------------------------------------
package arpt_pkg;

  localparam int COORD_W            = 32;
  localparam int AXIS_W             = 2;
  localparam int DEG_W              = 9;
  localparam int CFG_INDEX_W        = 1;
  localparam int CFG_DATA_W         = 9;
  localparam int COEF_FRAC_BITS_DEF = 16;

  localparam int DEG_PER_HALF_TURN = 180;
  localparam int DEG_FULL_TURN     = 2 * DEG_PER_HALF_TURN;
  localparam int DEG_QUARTER       = DEG_PER_HALF_TURN / 2;
  localparam int ROM_DEPTH         = DEG_QUARTER + 1;
  localparam int ROM_IDX_W         = $clog2(ROM_DEPTH);

  localparam longint unsigned PI_Q32 = 64'd13493037705;
  localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

  localparam logic [CFG_INDEX_W-1:0] REG_AXIS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEGREES = 1'b1;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_PASS = 2'd3
  } axis_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
    logic                      last_point;
  } pt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                      last_out;
    logic                      saturated;
  } pt_out_t;

  // sin(k degrees) with frac fractional bits, from a fixed-point taylor series
  function automatic longint unsigned sine_rom_entry(input int k, input int frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned one;
    longint unsigned r;
    longint          sum;
    one = 64'd1 << frac;
    if (k == 0) begin
      return 64'd0;
    end
    if (k >= DEG_QUARTER) begin
      return one;
    end
    x = (longint'(k) * PI_Q32 + 2 * DEG_PER_HALF_TURN) / (4 * DEG_PER_HALF_TURN);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    r = (longint'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
    if (r > one) begin
      r = one;
    end
    return r;
  endfunction

endpackage

>>> rtl/axis_rotation_point_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_rotation_point_transform
// Rotates a stream of Q16.16 points about the x, y or z axis by a whole
// number of degrees, with round-to-nearest and 32-bit saturation.
// ----------------------------------------------------------------------------
// Each beat is one point; the block takes one point per clock while the output
// is not stalled and returns one result per point, in order, through the stages
// operand select, four multiplies, add and round, and saturate.
// Every stage holds its own valid bit, so bubbles close up and a point is
// taken whenever the first stage is free or moving on. Writing the degrees
// register loads the cosine and sine coefficients at that same clock edge;
// axis code 3 passes points through unchanged with the saturated flag clear.
// ----------------------------------------------------------------------------
module axis_rotation_point_transform #(
  parameter int COEF_FRAC_BITS = arpt_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  arpt_pkg::pt_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output arpt_pkg::pt_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [arpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [arpt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import arpt_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = COORD_W + CW;
  localparam int SW = PW + 1;
  localparam int RW = SW - COEF_FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

  axis_t                 cfg_axis;
  logic signed [CW-1:0]  cos_coef;
  logic signed [CW-1:0]  sin_coef;

  arpt_cfg #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .axis      (cfg_axis),
    .cos_coef  (cos_coef),
    .sin_coef  (sin_coef)
  );

  // stage load enables, bubbles collapse
  logic ld1, ld2, ld3, ld4;

  logic                      s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  pt_in_t                    s1_pt_r, s2_pt_r, s3_pt_r;
  axis_t                     s1_axis_r, s2_axis_r, s3_axis_r;
  logic signed [COORD_W-1:0] s1_a_r, s1_b_r;
  logic signed [COORD_W-1:0] s1_a_nxt, s1_b_nxt;
  logic signed [PW-1:0]      s2_ca_r, s2_sb_r, s2_sa_r, s2_cb_r;
  logic signed [SW-1:0]      s3_p_r, s3_q_r;
  pt_out_t                   out_data_r, out_data_nxt;

  assign ld4 = !out_valid_r || !out_stall;
  assign ld3 = !s3_valid_r || ld4;
  assign ld2 = !s2_valid_r || ld3;
  assign ld1 = !s1_valid_r || ld2;
  assign in_stall = !ld1;

  // p = c*a - s*b, q = s*a + c*b
  always_comb begin
    case (cfg_axis)
      AXIS_X: begin
        s1_a_nxt = in_data.y_in;
        s1_b_nxt = in_data.z_in;
      end
      AXIS_Y: begin
        s1_a_nxt = in_data.z_in;
        s1_b_nxt = in_data.x_in;
      end
      default: begin
        s1_a_nxt = in_data.x_in;
        s1_b_nxt = in_data.y_in;
      end
    endcase
  end

  function automatic logic [COORD_W:0] sat32(input logic [RW-1:0] v);
    logic fits;
    fits = (v[RW-1:COORD_W-1] == '0) || (v[RW-1:COORD_W-1] == '1);
    if (fits) begin
      return {1'b0, v[COORD_W-1:0]};
    end else if (v[RW-1]) begin
      return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic [COORD_W:0] sat_p, sat_q;

  always_comb begin
    sat_p = sat32(s3_p_r[SW-1:COEF_FRAC_BITS]);
    sat_q = sat32(s3_q_r[SW-1:COEF_FRAC_BITS]);
    out_data_nxt.x_out     = s3_pt_r.x_in;
    out_data_nxt.y_out     = s3_pt_r.y_in;
    out_data_nxt.z_out     = s3_pt_r.z_in;
    out_data_nxt.last_out  = s3_pt_r.last_point;
    out_data_nxt.saturated = 1'b0;
    case (s3_axis_r)
      AXIS_X: begin
        out_data_nxt.y_out     = sat_p[COORD_W-1:0];
        out_data_nxt.z_out     = sat_q[COORD_W-1:0];
        out_data_nxt.saturated = sat_p[COORD_W] | sat_q[COORD_W];
      end
      AXIS_Y: begin
        out_data_nxt.z_out     = sat_p[COORD_W-1:0];
        out_data_nxt.x_out     = sat_q[COORD_W-1:0];
        out_data_nxt.saturated = sat_p[COORD_W] | sat_q[COORD_W];
      end
      AXIS_Z: begin
        out_data_nxt.x_out     = sat_p[COORD_W-1:0];
        out_data_nxt.y_out     = sat_q[COORD_W-1:0];
        out_data_nxt.saturated = sat_p[COORD_W] | sat_q[COORD_W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_valid_r <= in_valid;
      end
      if (ld2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (ld3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (ld4) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_pt_r   <= in_data;
      s1_axis_r <= cfg_axis;
      s1_a_r    <= s1_a_nxt;
      s1_b_r    <= s1_b_nxt;
    end
    if (ld2) begin
      s2_pt_r   <= s1_pt_r;
      s2_axis_r <= s1_axis_r;
      s2_ca_r   <= PW'(s1_a_r * cos_coef);
      s2_sb_r   <= PW'(s1_b_r * sin_coef);
      s2_sa_r   <= PW'(s1_a_r * sin_coef);
      s2_cb_r   <= PW'(s1_b_r * cos_coef);
    end
    if (ld3) begin
      s3_pt_r   <= s2_pt_r;
      s3_axis_r <= s2_axis_r;
      s3_p_r    <= SW'(s2_ca_r) - SW'(s2_sb_r) + HALF;
      s3_q_r    <= SW'(s2_sa_r) + SW'(s2_cb_r) + HALF;
    end
    if (ld4) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && s1_valid_r && s2_valid_r && s3_valid_r |-> in_stall)
    else $error("full pipeline accepted a beat while the output was stalled");

  a_coef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_DEGREES && cfg_wdata[DEG_W-1:0] == '0
    |=> cos_coef == COEF_ONE && sin_coef == '0)
    else $error("zero angle did not load unit cosine");

  a_coef_right: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_DEGREES && cfg_wdata[DEG_W-1:0] == DEG_W'(DEG_QUARTER)
    |=> cos_coef == '0 && sin_coef == COEF_ONE)
    else $error("right angle did not load unit sine");

endmodule

>>> rtl/arpt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpt_cfg
// Configuration registers: rotation axis, and the cosine / sine coefficients
// loaded through quadrant folding of a quarter-wave sine table.
// ----------------------------------------------------------------------------
module arpt_cfg #(
  parameter int COEF_FRAC_BITS = arpt_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [arpt_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [arpt_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  output arpt_pkg::axis_t                         axis,
  output logic signed [COEF_FRAC_BITS+1:0]        cos_coef,
  output logic signed [COEF_FRAC_BITS+1:0]        sin_coef
);
  import arpt_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

  logic [CW-1:0] sine_tab [ROM_DEPTH];

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_tab
    assign sine_tab[k] = CW'(sine_rom_entry(k, COEF_FRAC_BITS));
  end

  axis_t                 axis_r, axis_nxt;
  logic signed [CW-1:0]  cos_r, cos_nxt;
  logic signed [CW-1:0]  sin_r, sin_nxt;

  logic [DEG_W-1:0]      deg;
  logic [DEG_W-1:0]      deg_red;
  logic [1:0]            quad;
  logic [DEG_W-1:0]      quad_base;
  logic [ROM_IDX_W-1:0]  idx_s;
  logic [ROM_IDX_W-1:0]  idx_c;
  logic signed [CW-1:0]  s_val;
  logic signed [CW-1:0]  c_val;

  always_comb begin
    deg = cfg_wdata[DEG_W-1:0];
    deg_red = (deg >= DEG_W'(DEG_FULL_TURN)) ? deg - DEG_W'(DEG_FULL_TURN) : deg;
    if (deg_red < DEG_W'(DEG_QUARTER)) begin
      quad = 2'd0;
    end else if (deg_red < DEG_W'(2 * DEG_QUARTER)) begin
      quad = 2'd1;
    end else if (deg_red < DEG_W'(3 * DEG_QUARTER)) begin
      quad = 2'd2;
    end else begin
      quad = 2'd3;
    end
    quad_base = DEG_W'(DEG_QUARTER) * DEG_W'(quad);
    idx_s = ROM_IDX_W'(deg_red - quad_base);
    idx_c = ROM_IDX_W'(DEG_QUARTER) - idx_s;
    s_val = $signed(sine_tab[idx_s]);
    c_val = $signed(sine_tab[idx_c]);
  end

  always_comb begin
    axis_nxt = axis_r;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS: begin
          axis_nxt = axis_t'(cfg_wdata[AXIS_W-1:0]);
        end
        REG_DEGREES: begin
          unique case (quad)
            2'd0: begin
              sin_nxt = s_val;
              cos_nxt = c_val;
            end
            2'd1: begin
              sin_nxt = c_val;
              cos_nxt = -s_val;
            end
            2'd2: begin
              sin_nxt = -s_val;
              cos_nxt = -c_val;
            end
            default: begin
              sin_nxt = -c_val;
              cos_nxt = s_val;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_X;
      cos_r  <= COEF_ONE;
      sin_r  <= '0;
    end else begin
      axis_r <= axis_nxt;
      cos_r  <= cos_nxt;
      sin_r  <= sin_nxt;
    end
  end

  assign axis     = axis_r;
  assign cos_coef = cos_r;
  assign sin_coef = sin_r;

endmodule

>>> dv/arpt_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpt_rotation_checker
// Passive scoreboard for the principal-axis point rotation block. It follows
// the register writes, keeps its own axis and cosine/sine coefficients built
// from a fixed-point sine series, predicts the rotated point for every
// accepted input beat and compares every accepted result beat, in order,
// against the oldest prediction.
// ----------------------------------------------------------------------------
module arpt_rotation_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  arpt_pkg::pt_in_t                 in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  arpt_pkg::pt_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [arpt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [arpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               mismatch_count,
  output int                               outstanding
);
  import arpt_pkg::*;

  localparam int              FRAC         = COEF_FRAC_BITS_DEF;
  localparam int              UNITY        = 1 << FRAC;
  localparam int              FULL_TURN    = 360;
  localparam int              QUARTER_TURN = 90;
  localparam longint unsigned PI_SCALED    = 64'd13493037705;
  localparam longint          COORD_MAX    = 64'sd2147483647;
  localparam longint          COORD_MIN    = -64'sd2147483648;
  localparam int              REPORT_LIMIT = 10;

  axis_t   rot_axis;
  int      cos_q;
  int      sin_q;
  pt_out_t expected_points[$];

  // sin(k degrees) for k in 0..90, series in q30 then rounded to FRAC bits
  function automatic int quarter_sine(input int k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    if (k == 0) begin
      return 0;
    end
    if (k >= QUARTER_TURN) begin
      return UNITY;
    end
    ang = (longint'(k) * PI_SCALED + 64'd360) / 64'd720;
    ang_sq = (ang * ang) >> 30;
    term = ang;
    acc = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    rounded = (longint'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    if (rounded > UNITY) begin
      rounded = UNITY;
    end
    return int'(rounded);
  endfunction

  // quadrant folding of the quarter-wave table
  function automatic void load_coefficients(input int deg);
    int d;
    int rem;
    int s;
    int c;
    d = deg % FULL_TURN;
    rem = d % QUARTER_TURN;
    s = quarter_sine(rem);
    c = quarter_sine(QUARTER_TURN - rem);
    case (d / QUARTER_TURN)
      0: begin
        sin_q = s;
        cos_q = c;
      end
      1: begin
        sin_q = c;
        cos_q = -s;
      end
      2: begin
        sin_q = -s;
        cos_q = -c;
      end
      default: begin
        sin_q = -c;
        cos_q = s;
      end
    endcase
  endfunction

  // round half up to the coordinate scale, clip to 32 bits; msb is the clip flag
  function automatic logic [COORD_W:0] round_sat(input longint acc);
    longint v;
    v = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (v > COORD_MAX) begin
      return {1'b1, 32'h7fff_ffff};
    end
    if (v < COORD_MIN) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[COORD_W-1:0]};
  endfunction

  function automatic pt_out_t rotate_point(input pt_in_t p);
    longint             px;
    longint             py;
    longint             pz;
    longint             c;
    longint             s;
    logic [COORD_W:0]   ra;
    logic [COORD_W:0]   rb;
    pt_out_t            r;
    px = longint'($signed(p.x_in));
    py = longint'($signed(p.y_in));
    pz = longint'($signed(p.z_in));
    c = longint'(cos_q);
    s = longint'(sin_q);
    r.x_out = p.x_in;
    r.y_out = p.y_in;
    r.z_out = p.z_in;
    r.last_out = p.last_point;
    r.saturated = 1'b0;
    case (rot_axis)
      AXIS_X: begin
        ra = round_sat(c * py - s * pz);
        rb = round_sat(s * py + c * pz);
        r.y_out = ra[COORD_W-1:0];
        r.z_out = rb[COORD_W-1:0];
        r.saturated = ra[COORD_W] | rb[COORD_W];
      end
      AXIS_Y: begin
        ra = round_sat(c * px + s * pz);
        rb = round_sat(c * pz - s * px);
        r.x_out = ra[COORD_W-1:0];
        r.z_out = rb[COORD_W-1:0];
        r.saturated = ra[COORD_W] | rb[COORD_W];
      end
      AXIS_Z: begin
        ra = round_sat(c * px - s * py);
        rb = round_sat(s * px + c * py);
        r.x_out = ra[COORD_W-1:0];
        r.y_out = rb[COORD_W-1:0];
        r.saturated = ra[COORD_W] | rb[COORD_W];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pt_out_t want;
    if (!rst_n) begin
      rot_axis = AXIS_X;
      cos_q = UNITY;
      sin_q = 0;
      expected_points.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: result beat with nothing expected: x=%h y=%h z=%h last=%b sat=%b",
                     $realtime, out_data.x_out, out_data.y_out, out_data.z_out,
                     out_data.last_out, out_data.saturated);
          end
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (out_data.x_out !== want.x_out || out_data.y_out !== want.y_out ||
              out_data.z_out !== want.z_out || out_data.last_out !== want.last_out ||
              out_data.saturated !== want.saturated) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch: exp x=%h y=%h z=%h last=%b sat=%b",
                       $realtime, want.x_out, want.y_out, want.z_out, want.last_out,
                       want.saturated);
              $display("%0t:                  got x=%h y=%h z=%h last=%b sat=%b",
                       $realtime, out_data.x_out, out_data.y_out, out_data.z_out,
                       out_data.last_out, out_data.saturated);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_points.push_back(rotate_point(in_data));
      end
      if (cfg_we) begin
        if (cfg_index == REG_AXIS) begin
          rot_axis = axis_t'(cfg_wdata[AXIS_W-1:0]);
        end else if (cfg_index == REG_DEGREES) begin
          load_coefficients(int'(cfg_wdata));
        end
      end
    end
    outstanding = expected_points.size();
  end

endmodule

>>> dv/axis_rotation_point_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_rotation_point_transform_tb
// Drives point beats into the rotation block in random bursts while the
// result side stalls on its own pattern. A directed pass covers coordinate
// extremes, every axis including pass-through, angles past a full turn and
// saturating cases; random phases then sweep axis and angle settings, each
// phase starting only once every result has drained. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module axis_rotation_point_transform_tb;
  import arpt_pkg::*;

  localparam int RANDOM_POINTS = 1850;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 24;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_e;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  pt_in_t                 in_data;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  pt_out_t                out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int             mismatch_count;
  int             outstanding;
  int             cycle_count = 0;
  int             stall_left = 0;
  stall_pattern_e stall_pattern = STALL_NONE;

  pt_in_t corner_points[4];
  axis_t  dir_axis[6] = '{AXIS_X, AXIS_Z, AXIS_PASS, AXIS_Y, AXIS_X, AXIS_Z};
  int     dir_deg[6]  = '{0, 180, 45, 450, 45, 511};

  always #2 clk = ~clk;

  axis_rotation_point_transform dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  arpt_rotation_checker u_scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side back-pressure, switching to a new random pattern when each random run ends
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_pattern = stall_pattern_e'($urandom_range(0, 4));
      stall_left = $urandom_range(5, 60);
    end
    stall_left = stall_left - 1;
    case (stall_pattern)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 7 < 3);
    endcase
  end

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 6))
      0, 1: return $urandom();
      2: return int'($urandom_range(0, 131072)) - 65536;
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      5: return $signed($urandom()) >>> $urandom_range(0, 31);
      default: return {16'($urandom()), 16'h8000};
    endcase
  endfunction

  function automatic pt_in_t random_point();
    pt_in_t p;
    p.x_in = random_coord();
    p.y_in = random_coord();
    p.z_in = random_coord();
    p.last_point = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_point(input pt_in_t p);
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_rotation(input axis_t ax, input int deg);
    drain();
    write_reg(REG_AXIS, int'(ax));
    write_reg(REG_DEGREES, deg);
  endtask

  initial begin
    int    sent;
    int    phase;
    int    count;
    int    burst_left;
    axis_t ax;
    int    deg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_AXIS;
    cfg_wdata = '0;
    corner_points[0] = '{x_in: 32'h7fff_ffff, y_in: 32'h7fff_ffff, z_in: 32'h7fff_ffff,
                         last_point: 1'b0};
    corner_points[1] = '{x_in: 32'h8000_0000, y_in: 32'h8000_0000, z_in: 32'h8000_0000,
                         last_point: 1'b1};
    corner_points[2] = '{x_in: 32'h8000_0000, y_in: 32'h7fff_ffff, z_in: 32'h0000_8000,
                         last_point: 1'b0};
    corner_points[3] = '{x_in: 32'h0000_0001, y_in: 32'hffff_ffff, z_in: 32'h0000_0000,
                         last_point: 1'b1};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset coefficients first, then half turn, pass-through,
    // angles past a full turn and a diagonal that overflows
    for (int k = 0; k < 6; k++) begin
      if (k > 0) begin
        set_rotation(dir_axis[k], dir_deg[k]);
      end
      for (int i = 0; i < 4; i++) begin
        drive_point(corner_points[i]);
      end
    end

    sent = 0;
    phase = 0;
    burst_left = 0;
    while (sent < RANDOM_POINTS) begin
      case (phase)
        0: begin
          ax = AXIS_Y;
          deg = 359;
        end
        1: begin
          ax = AXIS_Z;
          deg = 360;
        end
        2: begin
          ax = AXIS_PASS;
          deg = 0;
        end
        3: begin
          ax = AXIS_X;
          deg = 90;
        end
        default: begin
          ax = axis_t'($urandom_range(0, 3));
          deg = ($urandom_range(0, 3) == 0) ? 90 * $urandom_range(0, 5)
                                             : $urandom_range(0, 511);
        end
      endcase
      set_rotation(ax, deg);
      count = $urandom_range(60, 200);
      for (int i = 0; i < count && sent < RANDOM_POINTS; i++) begin
        if (burst_left == 0) begin
          hold_off(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 60);
        end
        drive_point(random_point());
        burst_left--;
        sent++;
      end
      phase++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/arpt_pkg.sv
rtl/arpt_cfg.sv
rtl/axis_rotation_point_transform.sv
dv/arpt_rotation_checker.sv
dv/axis_rotation_point_transform_tb.sv
